FILE: design/srecord_encoder_defines.svh
// Assertion helpers shared by the encoder modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SRECORD_ENCODER_DEFINES_SVH
`define SRECORD_ENCODER_DEFINES_SVH

// Clocked property, off during reset.
`define SREC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold.
`define SREC_ASSERT_NEVER(lbl, cond, msg) \
  `SREC_ASSERT(lbl, !(cond), msg)

`endif

FILE: design/srec_pkg.sv
package srec_pkg;

  localparam int unsigned MaxRecordBytes = 16;
  localparam int unsigned FillW          = 5;
  localparam int unsigned AddrW          = 32;

  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOAD_ADDR = 2'd0;
  localparam logic [1:0] CFG_REC_TYPE  = 2'd1;

  // Input actions
  localparam logic [1:0] ACT_PUSH        = 2'd0;
  localparam logic [1:0] ACT_PUSH_FINISH = 2'd1;
  localparam logic [1:0] ACT_FINISH      = 2'd2;

  localparam logic [3:0] END_DIGIT_BASE = 4'd10;

  typedef struct packed {
    logic             start;
    logic             last;      // record closes the run of its input
    logic             end_rec;   // end record of the stream
    logic [3:0]       digit;
    logic [2:0]       abytes;
    logic [FillW-1:0] nbytes;
    logic [AddrW-1:0] addr;
  } srec_cmd_t;

  typedef struct packed {
    logic busy;
    logic rec_done;
  } srec_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CH_0 + {4'b0, nib};
    end else begin
      res = CH_A + {4'b0, nib - 4'd10};
    end
    return res;
  endfunction

endpackage

FILE: design/srecord_encoder.sv
// S-record encoder.
// Input channel (in_valid_i / in_stall_o): one action per transfer: push a
// byte, push a byte and finish, or finish only. A push that leaves the buffer
// short of RECORD_BYTES produces no characters; the byte is only buffered.
// A full buffer, or a finish with bytes pending, produces one data record:
// 'S', type, count, address, data and checksum in hex, then CR. A finish then
// produces the S9/S8/S7 end record and reloads the load address.
// Output channel (out_valid_o / out_stall_i): one ASCII character per
// transfer; last_of_run_o marks the final character of an input, and
// stream_done_o the CR of the end record.
// A record of n data bytes and a address bytes is 2n + 2a + 7 characters,
// put out by the single sequencer at one character per cycle while the
// receiver does not stall; data bytes come from the buffer memory read port.
// in_stall_o stays high while records are emitted.
// A stalled receiver holds the output register and freezes the sequencer.
// Reset empties the buffer, sets record type 1 and address zero. The user writes
// the configuration port only while the block is idle; the block does not enforce it.
module srecord_encoder import srec_pkg::*; #(
  parameter int unsigned RECORD_BYTES = MaxRecordBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ascii_char_o,
  output logic        last_of_run_o,
  output logic        stream_done_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e           state_q;
  logic             end_pend_q;
  logic [FillW-1:0] fill_q;
  logic [AddrW-1:0] load_addr_q;
  logic [AddrW-1:0] next_addr_q;
  logic [1:0]       rec_type_q;

  srec_cmd_t  cmd;
  srec_stat_t stat;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic             accept;
  logic             push;
  logic             fin;
  logic [FillW-1:0] fill_new;
  logic             data_rec;
  logic             launch_end;

  assign accept   = in_valid_i && !in_stall_o;
  assign push     = (action_i == ACT_PUSH) || (action_i == ACT_PUSH_FINISH);
  assign fin      = (action_i != ACT_PUSH);
  assign fill_new = push ? fill_q + FillW'(1) : fill_q;
  assign data_rec = accept && ((push && fill_new == FillW'(RECORD_BYTES))
                               || (fin && fill_new != '0));
  // End record goes straight out when nothing is buffered, else after the data record
  assign launch_end = (accept && fin && !data_rec)
                      || (state_q == ST_RUN && stat.rec_done && end_pend_q);

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd.start   = data_rec || launch_end;
    cmd.abytes  = {1'b0, rec_type_q} + 3'd1;
    cmd.addr    = next_addr_q;
    cmd.nbytes  = fill_new;
    if (data_rec) begin
      cmd.end_rec = 1'b0;
      cmd.last    = !fin;
      cmd.digit   = {2'b0, rec_type_q};
    end else begin
      cmd.end_rec = 1'b1;
      cmd.last    = 1'b1;
      cmd.nbytes  = '0;
      cmd.digit   = END_DIGIT_BASE - {2'b0, rec_type_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      end_pend_q  <= 1'b0;
      fill_q      <= '0;
      load_addr_q <= '0;
      next_addr_q <= '0;
      rec_type_q  <= 2'd1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOAD_ADDR: begin
            load_addr_q <= cfg_data_i;
            next_addr_q <= cfg_data_i;
          end
          CFG_REC_TYPE: begin
            if (cfg_data_i[1:0] != 2'd0) begin
              rec_type_q <= cfg_data_i[1:0];
            end
          end
          default: ;
        endcase
      end

      if (accept) begin
        fill_q <= (data_rec || fin) ? '0 : fill_new;
        if (data_rec || fin) begin
          state_q    <= ST_RUN;
          end_pend_q <= data_rec && fin;
        end
      end else if (state_q == ST_RUN && stat.rec_done) begin
        end_pend_q <= 1'b0;
        if (!end_pend_q) begin
          state_q <= ST_IDLE;
        end
      end

      if (data_rec) begin
        next_addr_q <= next_addr_q + AddrW'(fill_new);
      end else if (launch_end) begin
        next_addr_q <= load_addr_q;
      end
    end
  end

  srec_ram #(
    .WIDTH(8),
    .DEPTH(RECORD_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (accept && push),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  srec_emit #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ascii_char_o  (ascii_char_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o)
  );

  `include "srecord_encoder_defines.svh"

  `SREC_ASSERT_NEVER(a_idle_quiet, !in_stall_o && stat.busy, "ready while records pending")
  `SREC_ASSERT_NEVER(a_fill_range, fill_q >= FillW'(RECORD_BYTES), "buffer count overflow")
  `SREC_ASSERT(a_pend_run, end_pend_q |-> (state_q == ST_RUN), "end record pending when idle")

endmodule

FILE: design/srec_ram.sv
module srec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/srec_emit.sv
module srec_emit import srec_pkg::*; #(
  parameter int unsigned RECORD_BYTES = MaxRecordBytes,
  localparam int unsigned AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srec_cmd_t     cmd_i,
  output srec_stat_t    stat_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    ascii_char_o,
  output logic          last_of_run_o,
  output logic          stream_done_o
);

  typedef enum logic [3:0] {
    PH_S, PH_TYPE, PH_CNT_HI, PH_CNT_LO, PH_ADR_HI, PH_ADR_LO,
    PH_DAT_HI, PH_DAT_LO, PH_CK_HI, PH_CK_LO, PH_CR
  } phase_e;

  phase_e           phase_q;
  logic             busy_q;
  logic [4:0]       cnt_q;
  logic [FillW-1:0] nbytes_q;
  logic [2:0]       abytes_q;
  logic [AddrW-1:0] addr_q;
  logic [3:0]       digit_q;
  logic [7:0]       count_q;
  logic [7:0]       sum_q;
  logic             last_q;
  logic             end_q;
  logic             ov_q;
  logic [7:0]       och_q;
  logic             olast_q;
  logic             odone_q;

  logic       adv;
  logic [7:0] ch;
  logic [7:0] ck;
  logic       last_adr;
  logic       last_dat;
  logic [7:0] cmd_count;

  assign adv       = busy_q && (!ov_q || !out_stall_i);
  assign ck        = ~sum_q;
  assign last_adr  = (cnt_q == {2'b0, abytes_q - 3'd1});
  assign last_dat  = (cnt_q == 5'(nbytes_q - FillW'(1)));
  assign cmd_count = 8'(cmd_i.abytes) + 8'(cmd_i.nbytes) + 8'd1;

  always_comb begin
    case (phase_q)
      PH_S:      ch = CH_S;
      PH_TYPE:   ch = CH_0 + {4'b0, digit_q};
      PH_CNT_HI: ch = hex_char(count_q[7:4]);
      PH_CNT_LO: ch = hex_char(count_q[3:0]);
      PH_ADR_HI: ch = hex_char(addr_q[31:28]);
      PH_ADR_LO: ch = hex_char(addr_q[27:24]);
      PH_DAT_HI: ch = hex_char(rd_data_i[7:4]);
      PH_DAT_LO: ch = hex_char(rd_data_i[3:0]);
      PH_CK_HI:  ch = hex_char(ck[7:4]);
      PH_CK_LO:  ch = hex_char(ck[3:0]);
      PH_CR:     ch = CH_CR;
      default:   ch = CH_CR;
    endcase
  end

  // Prefetch the first data byte with the leading S, the next one with each data low nibble but the last
  assign rd_en_o   = adv && ((phase_q == PH_S) || (phase_q == PH_DAT_LO && !last_dat));
  assign rd_addr_o = (phase_q == PH_S) ? '0 : AW'(cnt_q + 5'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_S;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      nbytes_q <= '0;
      abytes_q <= '0;
      addr_q   <= '0;
      digit_q  <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      last_q   <= 1'b0;
      end_q    <= 1'b0;
      ov_q     <= 1'b0;
      och_q    <= '0;
      olast_q  <= 1'b0;
      odone_q  <= 1'b0;
    end else begin
      if (adv) begin
        ov_q    <= 1'b1;
        och_q   <= ch;
        olast_q <= (phase_q == PH_CR) && last_q;
        odone_q <= (phase_q == PH_CR) && end_q;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end

      if (cmd_i.start) begin
        busy_q   <= 1'b1;
        phase_q  <= PH_S;
        cnt_q    <= '0;
        nbytes_q <= cmd_i.nbytes;
        abytes_q <= cmd_i.abytes;
        digit_q  <= cmd_i.digit;
        last_q   <= cmd_i.last;
        end_q    <= cmd_i.end_rec;
        count_q  <= cmd_count;
        sum_q    <= cmd_count;
        // Left-align the address so its top byte goes out first
        case (cmd_i.abytes)
          3'd2:    addr_q <= cmd_i.addr << 16;
          3'd3:    addr_q <= cmd_i.addr << 8;
          default: addr_q <= cmd_i.addr;
        endcase
      end else if (adv) begin
        case (phase_q)
          PH_S:      phase_q <= PH_TYPE;
          PH_TYPE:   phase_q <= PH_CNT_HI;
          PH_CNT_HI: phase_q <= PH_CNT_LO;
          PH_CNT_LO: phase_q <= PH_ADR_HI;
          PH_ADR_HI: phase_q <= PH_ADR_LO;
          PH_ADR_LO: begin
            sum_q  <= sum_q + addr_q[31:24];
            addr_q <= addr_q << 8;
            if (last_adr) begin
              cnt_q   <= '0;
              phase_q <= (nbytes_q != '0) ? PH_DAT_HI : PH_CK_HI;
            end else begin
              cnt_q   <= cnt_q + 5'd1;
              phase_q <= PH_ADR_HI;
            end
          end
          PH_DAT_HI: phase_q <= PH_DAT_LO;
          PH_DAT_LO: begin
            sum_q <= sum_q + rd_data_i;
            if (last_dat) begin
              phase_q <= PH_CK_HI;
            end else begin
              cnt_q   <= cnt_q + 5'd1;
              phase_q <= PH_DAT_HI;
            end
          end
          PH_CK_HI:  phase_q <= PH_CK_LO;
          PH_CK_LO:  phase_q <= PH_CR;
          PH_CR: begin
            busy_q  <= 1'b0;
            phase_q <= PH_S;
          end
          default:   phase_q <= PH_S;
        endcase
      end
    end
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.rec_done = adv && (phase_q == PH_CR);

  assign out_valid_o   = ov_q;
  assign ascii_char_o  = och_q;
  assign last_of_run_o = olast_q;
  assign stream_done_o = odone_q;

  `include "srecord_encoder_defines.svh"

  `SREC_ASSERT(a_start_idle, cmd_i.start |-> (!busy_q || stat_o.rec_done), "start while busy")
  `SREC_ASSERT(a_cr_follows, stat_o.rec_done |=> (ov_q && och_q == CH_CR), "CR not loaded")
  `SREC_ASSERT_NEVER(a_rd_idle, rd_en_o && !busy_q, "buffer read while idle")
  `SREC_ASSERT(a_done_last, (ov_q && odone_q) |-> olast_q, "end CR not last of run")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import srec_pkg::*;

  // Action three decodes as a plain finish
  localparam logic [1:0] ACT_FINISH_ALT = 2'd3;
  localparam logic [1:0] CFG_SPARE_2    = 2'd2;
  localparam logic [1:0] CFG_SPARE_3    = 2'd3;
  localparam logic [1:0] TYPE_NONE      = 2'd0;
  localparam logic [1:0] TYPE_S1        = 2'd1;
  localparam logic [1:0] TYPE_S2        = 2'd2;
  localparam logic [1:0] TYPE_S3        = 2'd3;
  localparam int         SETTLE_CYCLES  = 4;
  localparam int         CYCLE_LIMIT    = 1000000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } srec_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  ascii_char_o;
  logic        last_of_run_o;
  logic        stream_done_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  srecord_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ascii_char_o  (ascii_char_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Encoder state as the testbench tracks it
  logic [31:0] load_addr_q;
  logic [31:0] next_addr_q;
  logic [1:0]  rec_type_q;
  logic [7:0]  byte_buf_q [MaxRecordBytes];
  int          fill_q;

  srec_char_t  run_chars[$];
  srec_char_t  pending_chars[$];
  string       hex_digits = "0123456789ABCDEF";

  int err_count   = 0;
  int cycle_count = 0;
  int send_pct    = 27;
  int recv_pct    = 73;
  int hold_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic int addr_len(input logic [1:0] rec_type);
    case (rec_type)
      TYPE_S1: return 2;
      TYPE_S2: return 3;
      default: return 4;
    endcase
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic done);
    srec_char_t e;
    e.ch   = ch;
    e.last = 1'b0;
    e.done = done;
    run_chars.push_back(e);
  endtask

  task automatic push_hex(input logic [7:0] b);
    push_char(hex_digits[b[7:4]], 1'b0);
    push_char(hex_digits[b[3:0]], 1'b0);
  endtask

  task automatic push_record(input logic [3:0] digit, input int nbytes, input logic is_end);
    int         abytes;
    logic [7:0] count;
    logic [7:0] sum;
    logic [7:0] b;
    abytes = addr_len(rec_type_q);
    count  = 8'(abytes + nbytes + 1);
    sum    = count;
    push_char(CH_S, 1'b0);
    push_char(CH_0 + digit, 1'b0);
    push_hex(count);
    for (int i = abytes - 1; i >= 0; i--) begin
      b = next_addr_q[i*8 +: 8];
      push_hex(b);
      sum += b;
    end
    for (int i = 0; i < nbytes; i++) begin
      push_hex(byte_buf_q[i]);
      sum += byte_buf_q[i];
    end
    push_hex(~sum);
    push_char(CH_CR, is_end);
  endtask

  task automatic flush_buffer();
    if (fill_q == 0) return;
    push_record({2'b00, rec_type_q}, fill_q, 1'b0);
    next_addr_q += fill_q;
    fill_q = 0;
  endtask

  // Work out the characters one accepted transfer produces
  task automatic predict_transfer(input logic [1:0] act, input logic [7:0] b);
    srec_char_t e;
    run_chars.delete();
    if (act == ACT_PUSH || act == ACT_PUSH_FINISH) begin
      if (fill_q < MaxRecordBytes) begin
        byte_buf_q[fill_q] = b;
        fill_q++;
      end
      if (fill_q >= MaxRecordBytes) flush_buffer();
    end
    if (act != ACT_PUSH) begin
      flush_buffer();
      push_record(END_DIGIT_BASE - {2'b00, rec_type_q}, 0, 1'b1);
      next_addr_q = load_addr_q;
      fill_q = 0;
    end
    foreach (run_chars[i]) begin
      e = run_chars[i];
      e.last = (i == run_chars.size() - 1);
      pending_chars.push_back(e);
    end
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [31:0] data);
    if (idx == CFG_LOAD_ADDR) begin
      load_addr_q = data;
      next_addr_q = data;
    end else if (idx == CFG_REC_TYPE) begin
      if (data[1:0] != TYPE_NONE) rec_type_q = data[1:0];
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one item and hold it until the transfer; leave valid high
  task automatic send_item(input logic [1:0] act, input logic [7:0] b);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_transfer(act, b);
  endtask

  task automatic send_run(input int nbytes, input logic [1:0] closing_act);
    for (int i = 0; i < nbytes; i++) send_item(ACT_PUSH, 8'($urandom_range(255)));
    send_item(closing_act, 8'($urandom_range(255)));
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_random_config();
    logic [31:0] addr;
    case ($urandom_range(3))
      0:       addr = 32'h0;
      1:       addr = 32'hFFFF_FFFF - $urandom_range(40);
      default: addr = $urandom;
    endcase
    write_reg(CFG_LOAD_ADDR, addr);
    write_reg(CFG_REC_TYPE, $urandom);
    if ($urandom_range(7) == 0) write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
  endtask

  task automatic test_defaults();
    send_item(ACT_PUSH, 8'h00);
    send_item(ACT_PUSH, 8'hFF);
    send_item(ACT_FINISH, 8'h00);
    // empty buffer: end record only
    send_item(ACT_FINISH, 8'hFF);
    drain_outputs();
  endtask

  task automatic test_full_record_wrap();
    logic [7:0] pattern [4];
    pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    write_reg(CFG_REC_TYPE, TYPE_S3);
    write_reg(CFG_LOAD_ADDR, 32'hFFFF_FFF8);
    for (int i = 0; i < MaxRecordBytes; i++) send_item(ACT_PUSH, pattern[i % 4]);
    // buffer went out when full, so only the end record follows
    send_item(ACT_FINISH_ALT, 8'h7F);
    drain_outputs();
  endtask

  task automatic test_config_quirks();
    write_reg(CFG_REC_TYPE, TYPE_S2);
    write_reg(CFG_REC_TYPE, TYPE_NONE);
    write_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_3, 32'h5555_5555);
    send_item(ACT_PUSH, 8'h80);
    drain_outputs();
    // new load address takes effect with a byte still buffered
    write_reg(CFG_LOAD_ADDR, 32'h00AB_CDEF);
    send_item(ACT_PUSH_FINISH, 8'h01);
    drain_outputs();
  endtask

  task automatic test_random_traffic(input int n_items);
    int         sent;
    int         len;
    logic [1:0] closing_act;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        drain_outputs();
        write_random_config();
      end
      len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 40);
      closing_act = 2'($urandom_range(ACT_PUSH_FINISH, ACT_FINISH_ALT));
      // leave some runs open so they carry into the next one
      if ($urandom_range(9) == 0) closing_act = ACT_PUSH;
      send_run(len, closing_act);
      sent += len + 1;
    end
    drain_outputs();
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    send_run(40, ACT_PUSH_FINISH);
    drain_outputs();
  endtask

  // Output side: random stall plus an optional long hold, and the check
  always @(posedge clk_i) begin : char_check
    srec_char_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %02h", ascii_char_o));
        end else begin
          e = pending_chars.pop_front();
          if (ascii_char_o !== e.ch)
            report_mismatch($sformatf("char %02h, want %02h", ascii_char_o, e.ch));
          if (last_of_run_o !== e.last)
            report_mismatch($sformatf("last_of_run %b, want %b", last_of_run_o, e.last));
          if (stream_done_o !== e.done)
            report_mismatch($sformatf("stream_done %b, want %b", stream_done_o, e.done));
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    in_valid_i  = 1'b0;
    action_i    = ACT_PUSH;
    data_byte_i = 8'h00;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_LOAD_ADDR;
    cfg_data_i  = 32'h0;
    rst_ni      = 1'b0;
    load_addr_q = 32'h0;
    next_addr_q = 32'h0;
    rec_type_q  = TYPE_S1;
    fill_q      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pct = 27;
    recv_pct = 73;
    test_defaults();
    test_full_record_wrap();
    test_config_quirks();
    test_random_traffic(60);

    send_pct = 73;
    recv_pct = 27;
    test_random_traffic(60);

    send_pct = 0;
    recv_pct = 0;
    test_random_traffic(60);
    test_backpressure();

    drain_outputs();
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: srecord_encoder.f
+incdir+design
design/srec_pkg.sv
design/srec_ram.sv
design/srec_emit.sv
design/srecord_encoder.sv
tb/tb.sv
